### hdl/kfcv_pkg.sv
// shared types, constants and the micro-program of the constant-velocity kalman filter
package kfcv_pkg;

  localparam int DATA_W    = 48;
  localparam int FRAC_W    = 24;
  localparam int HALF_W    = DATA_W / 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DIV_STEPS = DATA_W + FRAC_W;
  localparam int MUL_STEPS = 4;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int PC_W      = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_NOISE_POS   = 3'd1,
    CFG_NOISE_VEL   = 3'd2,
    CFG_MEAS_NOISE  = 3'd3,
    CFG_INIT_COV    = 3'd4,
    CFG_OBS_POS     = 3'd5,
    CFG_OBS_VEL     = 3'd6
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DONE
  } state_e;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BRS,
    OP_END
  } op_e;

  // operand sources: codes below 16 are register file slots
  typedef enum logic [4:0] {
    S_POS  = 5'd0,
    S_VEL  = 5'd1,
    S_PP   = 5'd2,
    S_PV   = 5'd3,
    S_VP   = 5'd4,
    S_VV   = 5'd5,
    S_T0   = 5'd6,
    S_T1   = 5'd7,
    S_Y    = 5'd8,
    S_G0   = 5'd9,
    S_G1   = 5'd10,
    S_S    = 5'd11,
    S_K0   = 5'd12,
    S_K1   = 5'd13,
    S_R0   = 5'd14,
    S_M    = 5'd15,
    S_DT   = 5'd16,
    S_QP   = 5'd17,
    S_QV   = 5'd18,
    S_R    = 5'd19,
    S_P0   = 5'd20,
    S_H0   = 5'd21,
    S_H1   = 5'd22,
    S_Z    = 5'd23,
    S_ZERO = 5'd24
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
  } instr_t;

  // entry point once the covariance has been loaded
  localparam logic [PC_W-1:0] PC_PRIMED = 6'd6;

  function automatic instr_t mk(input op_e op, input src_e a, input src_e b, input src_e dst);
    instr_t i;
    i.op  = op;
    i.a   = a;
    i.b   = b;
    i.dst = dst;
    return i;
  endfunction

  // micro-program: prelude, predict, update
  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // first beat: clear the state, load the covariance diagonal
      6'd0:  i = mk(OP_ADD, S_ZERO, S_ZERO, S_POS);
      6'd1:  i = mk(OP_ADD, S_ZERO, S_ZERO, S_VEL);
      6'd2:  i = mk(OP_ADD, S_P0,   S_ZERO, S_PP);
      6'd3:  i = mk(OP_ADD, S_P0,   S_ZERO, S_VV);
      6'd4:  i = mk(OP_ADD, S_ZERO, S_ZERO, S_PV);
      6'd5:  i = mk(OP_ADD, S_ZERO, S_ZERO, S_VP);
      // predict
      6'd6:  i = mk(OP_MUL, S_DT,   S_VEL,  S_M);
      6'd7:  i = mk(OP_ADD, S_POS,  S_M,    S_POS);
      6'd8:  i = mk(OP_MUL, S_DT,   S_VP,   S_M);
      6'd9:  i = mk(OP_ADD, S_PP,   S_M,    S_T0);
      6'd10: i = mk(OP_MUL, S_DT,   S_VV,   S_M);
      6'd11: i = mk(OP_ADD, S_PV,   S_M,    S_T1);
      6'd12: i = mk(OP_MUL, S_DT,   S_T1,   S_M);
      6'd13: i = mk(OP_ADD, S_T0,   S_M,    S_M);
      6'd14: i = mk(OP_ADD, S_M,    S_QP,   S_PP);
      6'd15: i = mk(OP_ADD, S_T1,   S_ZERO, S_PV);
      6'd16: i = mk(OP_MUL, S_DT,   S_VV,   S_M);
      6'd17: i = mk(OP_ADD, S_VP,   S_M,    S_VP);
      6'd18: i = mk(OP_ADD, S_VV,   S_QV,   S_VV);
      // innovation
      6'd19: i = mk(OP_MUL, S_H0,   S_POS,  S_M);
      6'd20: i = mk(OP_MUL, S_H1,   S_VEL,  S_T0);
      6'd21: i = mk(OP_ADD, S_M,    S_T0,   S_M);
      6'd22: i = mk(OP_SUB, S_Z,    S_M,    S_Y);
      // P H^T
      6'd23: i = mk(OP_MUL, S_PP,   S_H0,   S_M);
      6'd24: i = mk(OP_MUL, S_PV,   S_H1,   S_T0);
      6'd25: i = mk(OP_ADD, S_M,    S_T0,   S_G0);
      6'd26: i = mk(OP_MUL, S_VP,   S_H0,   S_M);
      6'd27: i = mk(OP_MUL, S_VV,   S_H1,   S_T0);
      6'd28: i = mk(OP_ADD, S_M,    S_T0,   S_G1);
      // innovation variance
      6'd29: i = mk(OP_MUL, S_H0,   S_G0,   S_M);
      6'd30: i = mk(OP_MUL, S_H1,   S_G1,   S_T0);
      6'd31: i = mk(OP_ADD, S_M,    S_T0,   S_M);
      6'd32: i = mk(OP_ADD, S_M,    S_R,    S_S);
      6'd33: i = mk(OP_BRS, S_S,    S_ZERO, S_M);
      // gain and state update
      6'd34: i = mk(OP_DIV, S_G0,   S_S,    S_K0);
      6'd35: i = mk(OP_DIV, S_G1,   S_S,    S_K1);
      6'd36: i = mk(OP_MUL, S_K0,   S_Y,    S_M);
      6'd37: i = mk(OP_ADD, S_POS,  S_M,    S_POS);
      6'd38: i = mk(OP_MUL, S_K1,   S_Y,    S_M);
      6'd39: i = mk(OP_ADD, S_VEL,  S_M,    S_VEL);
      // H P
      6'd40: i = mk(OP_MUL, S_H0,   S_PP,   S_M);
      6'd41: i = mk(OP_MUL, S_H1,   S_VP,   S_T0);
      6'd42: i = mk(OP_ADD, S_M,    S_T0,   S_R0);
      6'd43: i = mk(OP_MUL, S_H0,   S_PV,   S_M);
      6'd44: i = mk(OP_MUL, S_H1,   S_VV,   S_T0);
      6'd45: i = mk(OP_ADD, S_M,    S_T0,   S_T1);
      // covariance update
      6'd46: i = mk(OP_MUL, S_K0,   S_R0,   S_M);
      6'd47: i = mk(OP_SUB, S_PP,   S_M,    S_PP);
      6'd48: i = mk(OP_MUL, S_K0,   S_T1,   S_M);
      6'd49: i = mk(OP_SUB, S_PV,   S_M,    S_PV);
      6'd50: i = mk(OP_MUL, S_K1,   S_R0,   S_M);
      6'd51: i = mk(OP_SUB, S_VP,   S_M,    S_VP);
      6'd52: i = mk(OP_MUL, S_K1,   S_T1,   S_M);
      6'd53: i = mk(OP_SUB, S_VV,   S_M,    S_VV);
      default: i = mk(OP_END, S_ZERO, S_ZERO, S_M);
    endcase
    return i;
  endfunction

endpackage

### hdl/kalman_filter_const_velocity.sv
// two-state constant-velocity kalman filter on one shared multiply/divide/add unit
//
//  channel  | direction | signals
//  ---------+-----------+---------------------------------------------------------
//  in       | sink      | in_valid_i, in_ready_o, measurement_i
//  out      | source    | out_valid_o, out_ready_i, position_out_o, velocity_out_o, singular_o
//  cfg      | sink      | cfg_we_i, cfg_index_i, cfg_data_i
//
// one beat runs 48 micro-program steps and an end step (6 more on the first beat); each step
// passes a fetch state and then executes: add/sub write back at once, a multiply sums four
// 24x24 partial products and a divide makes one quotient bit a cycle, so the 23 multiplies and
// 2 bit-serial divides set the time from one accepted beat to the next; an update can be skipped.
// reset clears control and sets the configuration to its defaults; the state is loaded by the first beat.
// a finished result waits in the output register while the next beat is taken.
module kalman_filter_const_velocity (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [kfcv_pkg::DATA_W-1:0]  measurement_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [kfcv_pkg::DATA_W-1:0]  position_out_o,
  output logic signed [kfcv_pkg::DATA_W-1:0]  velocity_out_o,
  output logic                                singular_o,
  input  logic                                cfg_we_i,
  input  logic        [kfcv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [kfcv_pkg::DATA_W-1:0]  cfg_data_i
);
  import kfcv_pkg::*;

  localparam int MEM_D = 16;
  localparam int AW    = $clog2(MEM_D);

  state_e state_q, state_d;

  logic [DATA_W-2:0] dt_q, qp_q, qv_q, rn_q, p0_q;
  logic [DATA_W-1:0] h0_q, h1_q;
  logic [DATA_W-1:0] z_q;
  logic              primed_q, sing_q;
  logic [PC_W-1:0]   pc_q;
  logic [STEP_W-1:0] step_q;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [DATA_W-1:0] pos_sh_q, vel_sh_q;
  logic              out_valid_q, out_sing_q;
  logic [DATA_W-1:0] out_pos_q, out_vel_q;
  logic [DATA_W-1:0] rf_mem [MEM_D];

  instr_t            ins;
  logic [DATA_W-1:0] opa, opb;
  logic              in_acc, exec_done, wb_en, out_load, brs_skip;
  logic [DATA_W-1:0] wb_data;

  assign ins        = prog_rom(pc_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // operand selection
  function automatic logic [DATA_W-1:0] pick(input src_e s, input logic [DATA_W-1:0] rd);
    logic [DATA_W-1:0] v;
    case (s)
      S_DT:    v = {1'b0, dt_q};
      S_QP:    v = {1'b0, qp_q};
      S_QV:    v = {1'b0, qv_q};
      S_R:     v = {1'b0, rn_q};
      S_P0:    v = {1'b0, p0_q};
      S_H0:    v = h0_q;
      S_H1:    v = h1_q;
      S_Z:     v = z_q;
      S_ZERO:  v = '0;
      default: v = rd;
    endcase
    return v;
  endfunction

  assign opa = pick(ins.a, rd_a_q);
  assign opb = pick(ins.b, rd_b_q);

  // add and subtract with saturation
  logic [DATA_W:0] sum_w;
  logic [DATA_W-1:0] sum_sat;
  always_comb begin
    if (ins.op == OP_SUB) begin
      sum_w = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
    end else begin
      sum_w = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
    end
    if (sum_w[DATA_W] != sum_w[DATA_W-1]) begin
      sum_sat = sum_w[DATA_W] ? VMIN : VMAX;
    end else begin
      sum_sat = sum_w[DATA_W-1:0];
    end
  end

  // magnitudes for multiply and divide
  logic [DATA_W-1:0] mag_a, mag_b;
  assign mag_a = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
  assign mag_b = opb[DATA_W-1] ? (~opb + 1'b1) : opb;

  // multiply: one partial product per cycle
  logic [HALF_W-1:0]   part_a, part_b;
  logic [DATA_W-1:0]   part_p;
  logic [PROD_W-1:0]   part_sh;
  assign part_a = step_q[1] ? mag_a[DATA_W-1:HALF_W] : mag_a[HALF_W-1:0];
  assign part_b = step_q[0] ? mag_b[DATA_W-1:HALF_W] : mag_b[HALF_W-1:0];
  assign part_p = part_a * part_b;
  always_comb begin
    case (step_q[1:0])
      2'd0:    part_sh = {{DATA_W{1'b0}}, part_p};
      2'd3:    part_sh = {part_p, {DATA_W{1'b0}}};
      default: part_sh = {{HALF_W{1'b0}}, part_p, {HALF_W{1'b0}}};
    endcase
  end

  // product sign, scaling and saturation
  logic signed [PROD_W:0] prod_s, prod_sh;
  logic [DATA_W-1:0]      mul_res;
  always_comb begin
    prod_s  = (opa[DATA_W-1] ^ opb[DATA_W-1]) ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
    prod_sh = prod_s >>> FRAC_W;
    if (prod_sh > $signed({{(PROD_W-DATA_W+1){1'b0}}, VMAX})) begin
      mul_res = VMAX;
    end else if (prod_sh < $signed({{(PROD_W-DATA_W+1){1'b1}}, VMIN})) begin
      mul_res = VMIN;
    end else begin
      mul_res = prod_sh[DATA_W-1:0];
    end
  end

  // divide: restoring, one quotient bit per cycle
  logic [DIV_STEPS-1:0] numer;
  logic [STEP_W-1:0]    div_idx;
  logic [DATA_W:0]      rem_sh, rem_sub;
  logic [DATA_W-1:0]    div_res;
  assign numer   = {mag_a, {FRAC_W{1'b0}}};
  assign div_idx = STEP_W'(DIV_STEPS - 1) - step_q;
  assign rem_sh  = {rem_q, numer[div_idx]};
  assign rem_sub = rem_sh - {1'b0, opb};
  always_comb begin
    if (opa[DATA_W-1]) begin
      if (quo_q > DIV_STEPS'({1'b0, VMAX}) + 1'b1) begin
        div_res = VMIN;
      end else begin
        div_res = ~quo_q[DATA_W-1:0] + 1'b1;
      end
    end else if (quo_q > DIV_STEPS'({1'b0, VMAX})) begin
      div_res = VMAX;
    end else begin
      div_res = quo_q[DATA_W-1:0];
    end
  end

  // step completion, write back and unit next values
  always_comb begin
    exec_done = 1'b0;
    wb_en     = 1'b0;
    wb_data   = sum_sat;
    brs_skip  = 1'b0;
    acc_d     = acc_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    if (state_q == ST_FETCH) begin
      acc_d = '0;
      quo_d = '0;
      rem_d = '0;
    end else if (state_q == ST_EXEC) begin
      case (ins.op)
        OP_ADD, OP_SUB: begin
          exec_done = 1'b1;
          wb_en     = 1'b1;
        end
        OP_MUL: begin
          if (step_q == STEP_W'(MUL_STEPS)) begin
            exec_done = 1'b1;
            wb_en     = 1'b1;
            wb_data   = mul_res;
          end else begin
            acc_d = acc_q + part_sh;
          end
        end
        OP_DIV: begin
          if (step_q == STEP_W'(DIV_STEPS)) begin
            exec_done = 1'b1;
            wb_en     = 1'b1;
            wb_data   = div_res;
          end else if (!rem_sub[DATA_W]) begin
            rem_d = rem_sub[DATA_W-1:0];
            quo_d = {quo_q[DIV_STEPS-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[DATA_W-1:0];
            quo_d = {quo_q[DIV_STEPS-2:0], 1'b0};
          end
        end
        OP_BRS: begin
          exec_done = 1'b1;
          brs_skip  = opa[DATA_W-1] || (opa == '0);
        end
        default: exec_done = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC: begin
        if (ins.op == OP_END || brs_skip) begin
          state_d = ST_DONE;
        end else if (exec_done) begin
          state_d = ST_FETCH;
        end
      end
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      primed_q <= 1'b0;
      sing_q   <= 1'b0;
      pc_q     <= '0;
      step_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        primed_q <= 1'b1;
        sing_q   <= 1'b0;
        pc_q     <= primed_q ? PC_PRIMED : '0;
      end
      if (brs_skip) begin
        sing_q <= 1'b1;
      end
      if (state_q == ST_FETCH) begin
        step_q <= '0;
      end else if (state_q == ST_EXEC) begin
        if (exec_done) begin
          pc_q <= pc_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= (DATA_W-1)'(64'd16777216);
      qp_q <= (DATA_W-1)'(64'd168);
      qv_q <= (DATA_W-1)'(64'd168);
      rn_q <= (DATA_W-1)'(64'd838860800);
      p0_q <= (DATA_W-1)'(64'd16777216000000);
      h0_q <= DATA_W'(64'd16777216);
      h1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIME_STEP:  dt_q <= cfg_data_i[DATA_W-2:0];
        CFG_NOISE_POS:  qp_q <= cfg_data_i[DATA_W-2:0];
        CFG_NOISE_VEL:  qv_q <= cfg_data_i[DATA_W-2:0];
        CFG_MEAS_NOISE: rn_q <= cfg_data_i[DATA_W-2:0];
        CFG_INIT_COV:   p0_q <= cfg_data_i[DATA_W-2:0];
        CFG_OBS_POS:    h0_q <= cfg_data_i;
        CFG_OBS_VEL:    h1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unit datapath, sample and estimate shadows
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (in_acc) begin
      z_q <= measurement_i;
    end
    if (wb_en && ins.dst == S_POS) begin
      pos_sh_q <= wb_data;
    end
    if (wb_en && ins.dst == S_VEL) begin
      vel_sh_q <= wb_data;
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      rf_mem[ins.dst[AW-1:0]] <= wb_data;
    end
    if (state_q == ST_FETCH) begin
      rd_a_q <= rf_mem[ins.a[AW-1:0]];
      rd_b_q <= rf_mem[ins.b[AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q  <= pos_sh_q;
      out_vel_q  <= vel_sh_q;
      out_sing_q <= sing_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_out_o = out_pos_q;
  assign velocity_out_o = out_vel_q;
  assign singular_o     = out_sing_q;

endmodule

### bench/tb_kalman_filter_const_velocity.sv
// self-checking testbench of the constant-velocity kalman filter with a fixed-point predictor
module tb_kalman_filter_const_velocity;
  import kfcv_pkg::*;

  typedef logic signed [DATA_W-1:0] fx_t;

  typedef struct {
    fx_t  pos;
    fx_t  vel;
    logic sing;
  } estimate_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int                   STALL_LIMIT = 10000;
  localparam int                   LONG_HOLD   = 2000;
  localparam int                   SETTLE      = 400;
  localparam fx_t                  ONE         = 48'sd16777216;
  localparam logic [DATA_W-2:0]    UMAX        = '1;

  // tracks the filter state and the queue of expected estimates
  class estimate_board;
    fx_t       dt, q_pos, q_vel, r_meas, p_init, h_pos, h_vel;
    fx_t       x_pos, x_vel, c_pp, c_pv, c_vp, c_vv;
    bit        primed;
    estimate_t pending_q[$];
    int        errors;

    function new();
      dt = ONE; q_pos = 48'sd168; q_vel = 48'sd168;
      r_meas = 48'sd838860800; p_init = 48'sd16777216000000;
      h_pos = ONE; h_vel = '0;
      x_pos = '0; x_vel = '0; c_pp = '0; c_pv = '0; c_vp = '0; c_vv = '0;
      primed = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        CFG_TIME_STEP:  dt     = {1'b0, v[DATA_W-2:0]};
        CFG_NOISE_POS:  q_pos  = {1'b0, v[DATA_W-2:0]};
        CFG_NOISE_VEL:  q_vel  = {1'b0, v[DATA_W-2:0]};
        CFG_MEAS_NOISE: r_meas = {1'b0, v[DATA_W-2:0]};
        CFG_INIT_COV:   p_init = {1'b0, v[DATA_W-2:0]};
        CFG_OBS_POS:    h_pos  = v;
        CFG_OBS_VEL:    h_vel  = v;
        default: ;
      endcase
    endfunction

    function fx_t sat(logic signed [127:0] v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v[DATA_W-1:0];
    endfunction

    function fx_t add(fx_t a, fx_t b);
      logic signed [127:0] t;
      t = a;
      t = t + b;
      return sat(t);
    endfunction

    function fx_t sub(fx_t a, fx_t b);
      logic signed [127:0] t;
      t = a;
      t = t - b;
      return sat(t);
    endfunction

    // product rounded toward minus infinity
    function fx_t mul(fx_t a, fx_t b);
      logic signed [127:0] t;
      t = a;
      t = t * b;
      t = t >>> FRAC_W;
      return sat(t);
    endfunction

    // quotient truncated toward zero, den positive
    function fx_t div(fx_t num, fx_t den);
      logic signed [127:0] n, d;
      n = num;
      n = n <<< FRAC_W;
      d = den;
      return sat(n / d);
    endfunction

    // one predict and update pass for an accepted measurement
    function void note_measurement(fx_t z);
      fx_t       a, b, c, d, t0, t1, y, g0, g1, s, k0, k1, r0, r1;
      estimate_t e;
      if (!primed) begin
        c_pp = p_init; c_vv = p_init; c_pv = '0; c_vp = '0;
        primed = 1;
      end
      a = c_pp; b = c_pv; c = c_vp; d = c_vv;
      x_pos = add(x_pos, mul(dt, x_vel));
      t0 = add(a, mul(dt, c));
      t1 = add(b, mul(dt, d));
      c_pp = add(add(t0, mul(dt, t1)), q_pos);
      c_pv = t1;
      c_vp = add(c, mul(dt, d));
      c_vv = add(d, q_vel);
      y  = sub(z, add(mul(h_pos, x_pos), mul(h_vel, x_vel)));
      g0 = add(mul(c_pp, h_pos), mul(c_pv, h_vel));
      g1 = add(mul(c_vp, h_pos), mul(c_vv, h_vel));
      s  = add(add(mul(h_pos, g0), mul(h_vel, g1)), r_meas);
      e.sing = (s <= 0);
      if (!e.sing) begin
        k0 = div(g0, s);
        k1 = div(g1, s);
        x_pos = add(x_pos, mul(k0, y));
        x_vel = add(x_vel, mul(k1, y));
        r0 = add(mul(h_pos, c_pp), mul(h_vel, c_vp));
        r1 = add(mul(h_pos, c_pv), mul(h_vel, c_vv));
        c_pp = sub(c_pp, mul(k0, r0));
        c_pv = sub(c_pv, mul(k0, r1));
        c_vp = sub(c_vp, mul(k1, r0));
        c_vv = sub(c_vv, mul(k1, r1));
      end
      e.pos = x_pos;
      e.vel = x_vel;
      pending_q = {pending_q, e};
    endfunction

    function void check_estimate(fx_t pos, fx_t vel, logic sing);
      estimate_t e;
      if (pending_q.size() == 0) begin
        $error("estimate beat with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (pos !== e.pos) begin
        $error("position_out expected %0d actual %0d", e.pos, pos);
        errors++;
      end
      if (vel !== e.vel) begin
        $error("velocity_out expected %0d actual %0d", e.vel, vel);
        errors++;
      end
      if (sing !== e.sing) begin
        $error("singular expected %0b actual %0b", e.sing, sing);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 in_valid_i = 0;
  logic                 in_ready_o;
  fx_t                  measurement_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 0;
  fx_t                  position_out_o;
  fx_t                  velocity_out_o;
  logic                 singular_o;
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_TIME_STEP;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  estimate_board board = new();
  bit            calm = 0;
  bit            hold_req = 0;
  int            quiet_cycles = 0;

  kalman_filter_const_velocity uut (.*);

  // clock
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      board.check_estimate(position_out_o, velocity_out_o, singular_o);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i = 0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        out_ready_i = 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    board.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  // one measurement beat, called and returning at a falling edge
  task automatic send_measurement(fx_t z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i    = 1;
    measurement_i = z;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_measurement(z);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return DATA_W'({$urandom(), $urandom()});
  endfunction

  function automatic fx_t rand_measurement();
    case ($urandom_range(0, 9))
      0: return rand_word();
      1: return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return fx_t'($signed({$urandom_range(0, 1) ? 14'h3fff : 14'h0, $urandom(),
                                      2'($urandom_range(0, 3))}));
    endcase
  endfunction

  // mostly a plausible tracker setup, sometimes anything
  task automatic random_setup();
    write_reg(CFG_TIME_STEP, ($urandom_range(0, 4) == 0) ? rand_word()
                                                          : 48'($urandom_range(0, 1 << 25)));
    write_reg(CFG_NOISE_POS, ($urandom_range(0, 4) == 0) ? rand_word()
                                                          : 48'($urandom_range(0, 1 << 22)));
    write_reg(CFG_NOISE_VEL, ($urandom_range(0, 4) == 0) ? rand_word()
                                                          : 48'($urandom_range(0, 1 << 22)));
    write_reg(CFG_MEAS_NOISE, ($urandom_range(0, 4) == 0) ? rand_word()
                                                           : 48'($urandom_range(0, 32'hffffffff)));
    write_reg(CFG_INIT_COV, rand_word());
    write_reg(CFG_OBS_POS, ($urandom_range(0, 4) == 0) ? rand_word()
                          : 48'($signed(27'($urandom_range(0, 1 << 26) - (1 << 25)))));
    write_reg(CFG_OBS_VEL, ($urandom_range(0, 4) == 0) ? rand_word()
                          : 48'($signed(27'($urandom_range(0, 1 << 26) - (1 << 25)))));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // reset settings, an ignored index, field extremes
    write_reg(CFG_UNUSED, rand_word());
    send_measurement('0);
    send_measurement(VMAX);
    send_measurement(VMIN);
    send_measurement(fx_t'(1));
    send_measurement(-fx_t'(1));
    send_measurement(ONE * 10);
    send_measurement(-ONE * 3);
    wait_idle();

    // zero observation row and zero noise: update skipped
    write_reg(CFG_OBS_POS, '0);
    write_reg(CFG_OBS_VEL, '0);
    write_reg(CFG_MEAS_NOISE, '0);
    repeat (4) send_measurement(rand_measurement());
    wait_idle();

    // largest settings, saturating everywhere
    write_reg(CFG_TIME_STEP, {1'b0, UMAX});
    write_reg(CFG_NOISE_POS, {1'b0, UMAX});
    write_reg(CFG_NOISE_VEL, {1'b0, UMAX});
    write_reg(CFG_MEAS_NOISE, {1'b1, UMAX});
    write_reg(CFG_INIT_COV, {1'b0, UMAX});
    write_reg(CFG_OBS_POS, VMIN);
    write_reg(CFG_OBS_VEL, VMAX);
    send_measurement(VMAX);
    send_measurement(VMIN);
    send_measurement(rand_measurement());
    wait_idle();

    // smallest settings with a velocity-weighted row
    write_reg(CFG_TIME_STEP, '0);
    write_reg(CFG_NOISE_POS, '0);
    write_reg(CFG_NOISE_VEL, '0);
    write_reg(CFG_MEAS_NOISE, 48'd1);
    write_reg(CFG_OBS_POS, ONE);
    write_reg(CFG_OBS_VEL, -ONE);
    repeat (4) send_measurement(rand_measurement());
    wait_idle();

    // random phases; long receiver hold-off in the second, no idling in the last
    for (int phase = 0; phase < 6; phase++) begin
      random_setup();
      if (phase == 1) hold_req = 1;
      if (phase == 5) calm = 1;
      repeat (120) send_measurement(rand_measurement());
      wait_idle();
    end

    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
